[sv/hlcp_pkg.sv]
// ----------------------------------------------------------------------------
// hlcp_pkg: shared types and constants for the HSV lamp color to PWM block
// Command codes, sequencer step codes, control bundle, arithmetic constants.
// ----------------------------------------------------------------------------
package hlcp_pkg;

  // Field and datapath widths
  localparam int LEVEL_W = 16;
  localparam int MODE_W  = 3;
  localparam int PCT_W   = 7;   // percent, 0..100
  localparam int DUTY_W  = 14;
  localparam int MUL_W   = 24;  // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int HUE_W   = 9;   // hue after range check, 0..359
  localparam int RDEG_W  = 6;   // degrees inside a sector, 0..59
  localparam int FRAC_W  = 14;  // s*frac products, up to 10000
  localparam int NUM_W   = 20;  // v*(10000-...) up to 1,000,000
  localparam int SCL_W   = 22;  // pct*full scale, up to 3,276,800

  // Range limits and conversion constants
  localparam int HUE_MAX    = 360;
  localparam int PCT_MAX    = 100;
  localparam int SECTOR_DEG = 60;
  localparam int TENK       = 10000;

  // Reciprocal constants: floor(x/d) = (x*M) >> SH over the value range used
  localparam int RECIP3      = 683;      // x < 2048
  localparam int RECIP3_SH   = 11;
  localparam int RECIP100    = 5368710;  // x < 2**22
  localparam int RECIP100_SH = 29;
  localparam int RECIP10K    = 1717987;  // x < 2**20
  localparam int RECIP10K_SH = 34;

  // Command codes carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_SET_HUE = 3'd0,
    MODE_SET_SAT = 3'd1,
    MODE_SET_BRI = 3'd2,
    MODE_ON      = 3'd3,
    MODE_OFF     = 3'd4
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } state_t;

  // One multiplier operation per step
  typedef enum logic [3:0] {
    STP_FRAC, // frac = 5r/3
    STP_FS,   // frac*s
    STP_SNF,  // s*(100-frac)
    STP_VP,   // v*(100-s)
    STP_VQ,   // v*(10000-frac*s)
    STP_VT,   // v*(10000-s*(100-frac))
    STP_DP,   // p = /100
    STP_DQ,   // q = /10000
    STP_DT,   // t = /10000
    STP_SR,   // red pct * full scale
    STP_DR,   // red /100
    STP_SG,
    STP_DG,
    STP_SB,
    STP_DB
  } step_t;

  // Control bundle from the sequencer to the datapath
  typedef struct packed {
    step_t step;
    logic  calc;      // datapath step active
    logic  load_out;  // move duties to the output register
  } ctrl_t;

endpackage

[sv/hlcp_mul.sv]
// ----------------------------------------------------------------------------
// hlcp_mul: shared unsigned multiplier
// One 24x24 product per cycle, used by every step of the conversion.
// ----------------------------------------------------------------------------
module hlcp_mul
  import hlcp_pkg::*;
(
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  assign prod = PROD_W'(a) * PROD_W'(b);

endmodule

[sv/hlcp_ctrl.sv]
// ----------------------------------------------------------------------------
// hlcp_ctrl: conversion sequencer
// Walks the multiplier steps of one recompute, then hands the duties over
// to the output register once it is free.
// ----------------------------------------------------------------------------
module hlcp_ctrl
  import hlcp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,     // accepted command needs a recompute
  input  logic  in_range,  // stored hue, saturation, brightness are valid
  input  logic  out_free,  // output register can take a new item
  output logic  in_ready,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // State and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STP_FRAC;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    ctl.step     = step_r;
    ctl.calc     = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          state_nxt = ST_CALC;
          step_nxt  = STP_FRAC;
        end
      end
      ST_CALC: begin
        priority if (step_r == STP_FRAC && !in_range) begin
          // out-of-range value: no result
          state_nxt = ST_IDLE;
        end else if (step_r == STP_DB) begin
          ctl.calc  = 1'b1;
          state_nxt = ST_HOLD;
        end else begin
          ctl.calc = 1'b1;
          step_nxt = step_t'(step_r + 1'b1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[sv/hsv_light_color_to_pwm.sv]
// ----------------------------------------------------------------------------
// hsv_light_color_to_pwm: RGB lamp controller, HSV command to three duties
// Keeps hue, saturation, brightness and on state; a recompute converts HSV
// to RGB percent by sector and scales each channel to a PWM duty.
// ----------------------------------------------------------------------------
// A recomputing command walks 15 steps through the one shared 24x24
// multiplier, then holds until the output register is free; no new command
// is taken before the sequencer is back in idle. Other commands only update
// the state, and an out-of-range recompute stops at its first step.
// Reset: synchronous, active low; state clears to zero, lamp off, no item
// pending on the output.
module hsv_light_color_to_pwm
  import hlcp_pkg::*;
#(
  parameter int FULL_DUTY = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] level
  input  logic [2:0]  in_tuser,   // [2:0] mode
  // duty channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [13:0] red_duty, [27:14] green_duty,
                                  // [41:28] blue_duty, [47:42] zero
);

  // Lamp state
  logic [LEVEL_W-1:0] hue_r, sat_r, bri_r, saved_r;
  logic               lamp_on_r;

  logic  in_acc, start, in_range, out_free;
  ctrl_t ctl;

  assign in_acc = in_tvalid && in_tready;

  // Command decode: state update and recompute request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r     <= '0;
      sat_r     <= '0;
      bri_r     <= '0;
      saved_r   <= '0;
      lamp_on_r <= 1'b0;
    end else if (in_acc) begin
      unique case (in_tuser)
        MODE_SET_HUE: hue_r <= in_tdata;
        MODE_SET_SAT: sat_r <= in_tdata;
        MODE_SET_BRI: begin
          bri_r   <= in_tdata;
          saved_r <= in_tdata;
        end
        MODE_ON: begin
          bri_r     <= saved_r;
          lamp_on_r <= 1'b1;
        end
        MODE_OFF: begin
          saved_r   <= bri_r;
          bri_r     <= '0;
          lamp_on_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (in_tuser)
      MODE_SET_HUE, MODE_SET_SAT, MODE_SET_BRI: start = in_acc && lamp_on_r;
      MODE_ON, MODE_OFF:                         start = in_acc;
      default:                                   start = 1'b0;
    endcase
  end

  assign in_range = (hue_r <= LEVEL_W'(HUE_MAX)) && (sat_r <= LEVEL_W'(PCT_MAX))
                    && (bri_r <= LEVEL_W'(PCT_MAX));

  // Sequencer
  hlcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_range (in_range),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  // Sector split; hue 360 wraps to 0
  logic [HUE_W-1:0]  h_eff, base_deg;
  logic [2:0]        sector;
  logic [RDEG_W-1:0] r_deg;
  logic [HUE_W-1:0]  five_r;

  assign h_eff = (hue_r == LEVEL_W'(HUE_MAX)) ? '0 : hue_r[HUE_W-1:0];

  always_comb begin
    priority if (h_eff < HUE_W'(SECTOR_DEG))     sector = 3'd0;
    else if (h_eff < HUE_W'(2 * SECTOR_DEG))     sector = 3'd1;
    else if (h_eff < HUE_W'(3 * SECTOR_DEG))     sector = 3'd2;
    else if (h_eff < HUE_W'(4 * SECTOR_DEG))     sector = 3'd3;
    else if (h_eff < HUE_W'(5 * SECTOR_DEG))     sector = 3'd4;
    else                                         sector = 3'd5;
  end

  assign base_deg = HUE_W'(sector * SECTOR_DEG);
  assign r_deg    = RDEG_W'(h_eff - base_deg);
  assign five_r   = {1'b0, r_deg, 2'b00} + HUE_W'(r_deg);

  // Intermediate results
  logic [PCT_W-1:0]  frac_r, p_r, q_r, t_r;
  logic [FRAC_W-1:0] fs_r, snf_r, pn_r;
  logic [NUM_W-1:0]  qn_r, tn_r;
  logic [SCL_W-1:0]  scl_r;
  logic [DUTY_W-1:0] red_r, green_r, blue_r;

  logic [PCT_W-1:0]  v_pct, s_pct, s_comp, f_comp;
  logic [FRAC_W-1:0] q_fac, t_fac;

  assign v_pct  = bri_r[PCT_W-1:0];
  assign s_pct  = sat_r[PCT_W-1:0];
  assign s_comp = PCT_W'(PCT_MAX) - s_pct;
  assign f_comp = PCT_W'(PCT_MAX) - frac_r;
  assign q_fac  = FRAC_W'(TENK) - fs_r;
  assign t_fac  = FRAC_W'(TENK) - snf_r;

  // Channel percents by sector
  logic [PCT_W-1:0] r_pct, g_pct, b_pct;

  always_comb begin
    unique case (sector)
      3'd0:    begin r_pct = v_pct; g_pct = t_r;   b_pct = p_r;   end
      3'd1:    begin r_pct = q_r;   g_pct = v_pct; b_pct = p_r;   end
      3'd2:    begin r_pct = p_r;   g_pct = v_pct; b_pct = t_r;   end
      3'd3:    begin r_pct = p_r;   g_pct = q_r;   b_pct = v_pct; end
      3'd4:    begin r_pct = t_r;   g_pct = p_r;   b_pct = v_pct; end
      default: begin r_pct = v_pct; g_pct = p_r;   b_pct = q_r;   end
    endcase
  end

  // Operand select for the shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    unique case (ctl.step)
      STP_FRAC: begin mul_a = MUL_W'(five_r); mul_b = MUL_W'(RECIP3);    end
      STP_FS:   begin mul_a = MUL_W'(frac_r); mul_b = MUL_W'(s_pct);     end
      STP_SNF:  begin mul_a = MUL_W'(s_pct);  mul_b = MUL_W'(f_comp);    end
      STP_VP:   begin mul_a = MUL_W'(v_pct);  mul_b = MUL_W'(s_comp);    end
      STP_VQ:   begin mul_a = MUL_W'(v_pct);  mul_b = MUL_W'(q_fac);     end
      STP_VT:   begin mul_a = MUL_W'(v_pct);  mul_b = MUL_W'(t_fac);     end
      STP_DP:   begin mul_a = MUL_W'(pn_r);   mul_b = MUL_W'(RECIP100);  end
      STP_DQ:   begin mul_a = MUL_W'(qn_r);   mul_b = MUL_W'(RECIP10K);  end
      STP_DT:   begin mul_a = MUL_W'(tn_r);   mul_b = MUL_W'(RECIP10K);  end
      STP_SR:   begin mul_a = MUL_W'(r_pct);  mul_b = MUL_W'(FULL_DUTY); end
      STP_SG:   begin mul_a = MUL_W'(g_pct);  mul_b = MUL_W'(FULL_DUTY); end
      STP_SB:   begin mul_a = MUL_W'(b_pct);  mul_b = MUL_W'(FULL_DUTY); end
      STP_DR, STP_DG, STP_DB: begin
        mul_a = MUL_W'(scl_r);
        mul_b = MUL_W'(RECIP100);
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  hlcp_mul u_mul (
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Capture each product in its destination register
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      unique case (ctl.step)
        STP_FRAC: frac_r  <= prod[RECIP3_SH +: PCT_W];
        STP_FS:   fs_r    <= prod[FRAC_W-1:0];
        STP_SNF:  snf_r   <= prod[FRAC_W-1:0];
        STP_VP:   pn_r    <= prod[FRAC_W-1:0];
        STP_VQ:   qn_r    <= prod[NUM_W-1:0];
        STP_VT:   tn_r    <= prod[NUM_W-1:0];
        STP_DP:   p_r     <= prod[RECIP100_SH +: PCT_W];
        STP_DQ:   q_r     <= prod[RECIP10K_SH +: PCT_W];
        STP_DT:   t_r     <= prod[RECIP10K_SH +: PCT_W];
        STP_SR, STP_SG, STP_SB: scl_r <= prod[SCL_W-1:0];
        STP_DR:   red_r   <= prod[RECIP100_SH +: DUTY_W];
        STP_DG:   green_r <= prod[RECIP100_SH +: DUTY_W];
        STP_DB:   blue_r  <= prod[RECIP100_SH +: DUTY_W];
        default: ;
      endcase
    end
  end

  // Output register
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_tdata_r <= {6'd0, blue_r, green_r, red_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[sv/hlcp_chk.sv]
// ----------------------------------------------------------------------------
// hlcp_chk: port-level checks for the lamp color block
// Watches the command and duty channels; bound to the top level.
// ----------------------------------------------------------------------------
module hlcp_chk
  import hlcp_pkg::*;
#(
  parameter int FULL_DUTY = 8192
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("duty item changed while stalled");

  // Results only come out of a conversion, during which commands are held off
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("duty item appeared without a conversion");

  // Unused command codes start no work
  a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser > MODE_OFF) |=> in_tready)
    else $error("unused command started a conversion");

  // Duties stay within full scale when it fits the field
  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (FULL_DUTY < 16384) |->
      out_tdata[13:0] <= 14'(FULL_DUTY) && out_tdata[27:14] <= 14'(FULL_DUTY)
      && out_tdata[41:28] <= 14'(FULL_DUTY))
    else $error("duty above full scale");

endmodule

bind hsv_light_color_to_pwm hlcp_chk #(.FULL_DUTY(FULL_DUTY)) u_hlcp_chk (.*);
